/* hw/rtl/light_command_frame_builder_macros.svh */
// Assertion helpers for the frame builder checkers.
`ifndef LIGHT_COMMAND_FRAME_BUILDER_MACROS_SVH
`define LIGHT_COMMAND_FRAME_BUILDER_MACROS_SVH

// Checked only outside reset.
`define LCFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define LCFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/lcfb_pkg.sv */
package lcfb_pkg;

  localparam int unsigned TYPE_DIGITS_DEF   = 2;
  localparam int unsigned LENGTH_DIGITS_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  // Input opcodes
  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_START_FLAG = 1'b0;
  localparam logic REG_END_FLAG   = 1'b1;

  typedef enum logic [1:0] {
    JOB_HDR,
    JOB_DATA,
    JOB_ORPH
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        close;
    logic [7:0]  ctype;
    logic [15:0] plen;
    logic [7:0]  pbyte;
  } job_t;

  typedef enum logic [2:0] {
    ST_FIRST,
    ST_TYPE,
    ST_LEN,
    ST_CHK,
    ST_END
  } back_state_e;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h57 + {4'h0, nib};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/lcfb_in_if.sv */
interface lcfb_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  command_type;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (output valid, opcode, command_type, payload_length, payload_byte,
                  input ready);
  modport sink (input valid, opcode, command_type, payload_length, payload_byte,
                output ready);
endinterface

/* hw/rtl/lcfb_out_if.sv */
interface lcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       run_last;
  logic       frame_done;
  logic       orphan_error;

  modport source (output valid, frame_byte, run_last, frame_done, orphan_error,
                  input ready);
  modport sink (input valid, frame_byte, run_last, frame_done, orphan_error,
                output ready);
endinterface

/* hw/rtl/lcfb_front.sv */
module lcfb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcfb_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output lcfb_pkg::job_t job_o
);

  logic        frame_open_q, frame_open_d;
  logic [15:0] bytes_rem_q, bytes_rem_d;
  logic        accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  always_comb begin
    frame_open_d = frame_open_q;
    bytes_rem_d  = bytes_rem_q;
    job_o.kind   = lcfb_pkg::JOB_ORPH;
    job_o.close  = 1'b0;
    job_o.ctype  = in_i.command_type;
    job_o.plen   = in_i.payload_length;
    job_o.pbyte  = in_i.payload_byte;
    if (in_i.opcode == lcfb_pkg::OP_HEADER) begin
      job_o.kind  = lcfb_pkg::JOB_HDR;
      job_o.close = (in_i.payload_length == 16'd0);
      if (accept) begin
        frame_open_d = (in_i.payload_length != 16'd0);
        bytes_rem_d  = in_i.payload_length;
      end
    end else if (frame_open_q) begin
      job_o.kind  = lcfb_pkg::JOB_DATA;
      job_o.close = (bytes_rem_q == 16'd1);
      if (accept) begin
        bytes_rem_d = bytes_rem_q - 16'd1;
        if (bytes_rem_q == 16'd1) begin
          frame_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_rem_q  <= '0;
    end else begin
      frame_open_q <= frame_open_d;
      bytes_rem_q  <= bytes_rem_d;
    end
  end

endmodule

/* hw/rtl/lcfb_queue.sv */
module lcfb_queue #(
  parameter int unsigned DEPTH = lcfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcfb_pkg::job_t job_i,
  output logic           full_o,
  output logic           head_valid_o,
  output lcfb_pkg::job_t head_o,
  input  logic           pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcfb_pkg::job_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/lcfb_back.sv */
module lcfb_back #(
  parameter int unsigned TYPE_DIGITS   = lcfb_pkg::TYPE_DIGITS_DEF,
  parameter int unsigned LENGTH_DIGITS = lcfb_pkg::LENGTH_DIGITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  lcfb_pkg::job_t head_i,
  output logic           pop_o,
  input  logic [7:0]     start_flag_i,
  input  logic [7:0]     end_flag_i,
  lcfb_out_if.source     out_o
);

  localparam int unsigned MAXD  = (TYPE_DIGITS > LENGTH_DIGITS) ?
                                  ((TYPE_DIGITS > 2) ? TYPE_DIGITS : 2) :
                                  ((LENGTH_DIGITS > 2) ? LENGTH_DIGITS : 2);
  localparam int unsigned CNT_W = $clog2(MAXD);

  lcfb_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic             step;

  logic             out_valid_q;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, done_q, done_d, err_q, err_d;

  logic [31:0]      type_sh, len_sh;
  logic [7:0]       chk;
  logic [3:0]       chk_nib;
  logic [7:0]       type_char, len_char;

  assign step = head_valid_i && (!out_valid_q || out_o.ready);

  assign type_sh   = {24'h0, head_i.ctype} >> {cnt_q, 2'b00};
  assign len_sh    = {16'h0, head_i.plen} >> {cnt_q, 2'b00};
  assign type_char = lcfb_pkg::hex_char(type_sh[3:0]);
  assign len_char  = lcfb_pkg::hex_char(len_sh[3:0]);
  assign chk       = 8'h00 - sum_q;
  assign chk_nib   = cnt_q[0] ? chk[7:4] : chk[3:0];

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    if (step) begin
      unique case (state_q)
        lcfb_pkg::ST_FIRST: begin
          unique case (head_i.kind)
            lcfb_pkg::JOB_HDR: begin
              state_d = lcfb_pkg::ST_TYPE;
              cnt_d   = CNT_W'(TYPE_DIGITS - 1);
            end
            lcfb_pkg::JOB_DATA: begin
              if (head_i.close) begin
                state_d = lcfb_pkg::ST_CHK;
                cnt_d   = CNT_W'(1);
              end else begin
                pop_o = 1'b1;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
        lcfb_pkg::ST_TYPE: begin
          if (cnt_q == '0) begin
            state_d = lcfb_pkg::ST_LEN;
            cnt_d   = CNT_W'(LENGTH_DIGITS - 1);
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        lcfb_pkg::ST_LEN: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end else if (head_i.close) begin
            state_d = lcfb_pkg::ST_CHK;
            cnt_d   = CNT_W'(1);
          end else begin
            state_d = lcfb_pkg::ST_FIRST;
            pop_o   = 1'b1;
          end
        end
        lcfb_pkg::ST_CHK: begin
          if (cnt_q == '0) begin
            state_d = lcfb_pkg::ST_END;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        lcfb_pkg::ST_END: begin
          state_d = lcfb_pkg::ST_FIRST;
          pop_o   = 1'b1;
        end
        default: state_d = lcfb_pkg::ST_FIRST;
      endcase
    end
  end

  // outputs
  always_comb begin
    byte_d = '0;
    done_d = 1'b0;
    err_d  = 1'b0;
    sum_d  = sum_q;
    unique case (state_q)
      lcfb_pkg::ST_FIRST: begin
        unique case (head_i.kind)
          lcfb_pkg::JOB_HDR: begin
            byte_d = start_flag_i;
            sum_d  = '0;
          end
          lcfb_pkg::JOB_DATA: begin
            byte_d = head_i.pbyte;
            sum_d  = sum_q + head_i.pbyte;
          end
          default: err_d = 1'b1;
        endcase
      end
      lcfb_pkg::ST_TYPE: begin
        byte_d = type_char;
        sum_d  = sum_q + type_char;
      end
      lcfb_pkg::ST_LEN: begin
        byte_d = len_char;
        sum_d  = sum_q + len_char;
      end
      lcfb_pkg::ST_CHK: byte_d = lcfb_pkg::hex_char(chk_nib);
      lcfb_pkg::ST_END: begin
        byte_d = end_flag_i;
        done_d = 1'b1;
      end
      default: byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcfb_pkg::ST_FIRST;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        state_q     <= state_d;
        cnt_q       <= cnt_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= byte_d;
      last_q <= pop_o;
      done_q <= done_d;
      err_q  <= err_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_byte   = byte_q;
  assign out_o.run_last     = last_q;
  assign out_o.frame_done   = done_q;
  assign out_o.orphan_error = err_q;

endmodule

/* hw/rtl/light_command_frame_builder.sv */
// Light command frame builder.
// in_i takes header items (opcode 0: command type and payload length) and
// payload items (opcode 1: one raw byte); out_o gives the serialized frame one
// byte per transaction: start flag, type and length in lowercase ASCII hex,
// payload bytes, two hex checksum characters and the end flag (frame_done).
// run_last marks the final byte caused by each input transaction. A payload
// byte with no open frame gives one byte of zero with orphan_error set.
// Flags are written through the APB port (start at 0x0, end at 0x4).
// Throughput: the output sequencer emits one byte a cycle while the queue
// holds work and the receiver is not stalling; a payload byte gives one
// output byte, a header 1 + TYPE_DIGITS + LENGTH_DIGITS bytes, and a frame
// close 3 more. The input side keeps taking transactions into a
// QUEUE_DEPTH-entry queue while the sequencer works through a header.
// When the receiver stalls, the output register holds its byte, the
// sequencer stops, and in_i.ready drops once the queue is full.
// Reset clears both flags to 0, empties the queue and closes any frame.
module light_command_frame_builder #(
  parameter int unsigned TYPE_DIGITS   = lcfb_pkg::TYPE_DIGITS_DEF,
  parameter int unsigned LENGTH_DIGITS = lcfb_pkg::LENGTH_DIGITS_DEF,
  parameter int unsigned QUEUE_DEPTH   = lcfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcfb_in_if.sink     in_i,
  lcfb_out_if.source  out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [7:0]     start_flag_q, end_flag_q;
  logic           cfg_wr;
  logic           push, full, head_valid, pop;
  lcfb_pkg::job_t push_job, head_job;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_flag_q <= '0;
      end_flag_q   <= '0;
    end else if (cfg_wr) begin
      if (paddr_i[2] == lcfb_pkg::REG_START_FLAG) begin
        start_flag_q <= pwdata_i[7:0];
      end else begin
        end_flag_q <= pwdata_i[7:0];
      end
    end
  end

  assign prdata_o = (paddr_i[2] == lcfb_pkg::REG_END_FLAG) ? {24'h0, end_flag_q}
                                                           : {24'h0, start_flag_q};

  lcfb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  lcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (push_job),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_job),
    .pop_i        (pop)
  );

  lcfb_back #(
    .TYPE_DIGITS   (TYPE_DIGITS),
    .LENGTH_DIGITS (LENGTH_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .start_flag_i (start_flag_q),
    .end_flag_i   (end_flag_q),
    .out_o        (out_o)
  );

endmodule

/* hw/rtl/lcfb_checker.sv */
`include "light_command_frame_builder_macros.svh"

module lcfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       out_done_i,
  input logic       out_err_i
);

  `LCFB_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !out_valid_i, "output valid in reset")

  `LCFB_ASSERT(a_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i), "stalled output changed")

  `LCFB_ASSERT(a_done_is_last, out_valid_i && out_done_i |-> out_last_i && !out_err_i, "end flag not last of its transaction")

  `LCFB_ASSERT(a_orphan_shape, out_valid_i && out_err_i |-> out_last_i && (out_byte_i == 8'h00), "orphan result malformed")

endmodule

bind light_command_frame_builder lcfb_checker u_lcfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.frame_byte),
  .out_last_i  (out_o.run_last),
  .out_done_i  (out_o.frame_done),
  .out_err_i   (out_o.orphan_error)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CHECK_DIGITS = 2;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          LONG_STALL   = 300;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_done;
    logic       orphan_error;
  } frame_result_t;

  // Predicts the serialized bytes and checks them in order.
  class frame_scoreboard;
    frame_result_t expected_q[$];
    frame_result_t batch[$];
    logic [7:0]    start_flag = 8'h00;
    logic [7:0]    end_flag = 8'h00;
    bit            frame_is_open = 1'b0;
    logic [15:0]   remaining = 16'h0000;
    logic [7:0]    sum = 8'h00;
    int            errors = 0;
    int            results_seen = 0;
    int            headers = 0;
    int            payloads = 0;
    int            frames_closed = 0;
    int            orphans = 0;

    function void set_flag(logic idx, logic [7:0] value);
      if (idx == lcfb_pkg::REG_START_FLAG) begin
        start_flag = value;
      end else begin
        end_flag = value;
      end
    endfunction

    function void emit(logic [7:0] b, logic done, logic err);
      frame_result_t r;
      r.frame_byte   = b;
      r.run_last     = 1'b0;
      r.frame_done   = done;
      r.orphan_error = err;
      batch.push_back(r);
    endfunction

    // Low digits only, most significant first, lowercase.
    function void emit_hex(logic [15:0] v, int digits, bit summed);
      logic [3:0] nib;
      logic [7:0] c;
      for (int i = digits - 1; i >= 0; i--) begin
        nib = v[4*i +: 4];
        c = (nib < 4'd10) ? 8'h30 + nib : 8'h61 + (nib - 4'd10);
        if (summed) begin
          sum = sum + c;
        end
        emit(c, 1'b0, 1'b0);
      end
    endfunction

    function void close_frame();
      logic [7:0] check;
      check = 8'h00 - sum;  // two's complement of the byte sum, 00 when sum wraps to 0
      emit_hex({8'h00, check}, CHECK_DIGITS, 1'b0);
      emit(end_flag, 1'b1, 1'b0);
      frame_is_open = 1'b0;
      remaining = 16'h0000;
      sum = 8'h00;
      frames_closed++;
    endfunction

    function void note_item(logic op, logic [7:0] ctype, logic [15:0] plen,
                            logic [7:0] pbyte);
      batch.delete();
      if (op == lcfb_pkg::OP_HEADER) begin
        headers++;
        sum = 8'h00;
        emit(start_flag, 1'b0, 1'b0);
        emit_hex({8'h00, ctype}, lcfb_pkg::TYPE_DIGITS_DEF, 1'b1);
        emit_hex(plen, lcfb_pkg::LENGTH_DIGITS_DEF, 1'b1);
        frame_is_open = 1'b1;
        remaining = plen;
        if (plen == 16'h0000) begin
          close_frame();
        end
      end else begin
        payloads++;
        if (!frame_is_open) begin
          orphans++;
          emit(8'h00, 1'b0, 1'b1);
        end else begin
          sum = sum + pbyte;
          emit(pbyte, 1'b0, 1'b0);
          remaining = remaining - 16'd1;
          if (remaining == 16'h0000) begin
            close_frame();
          end
        end
      end
      batch[batch.size() - 1].run_last = 1'b1;
      foreach (batch[i]) begin
        expected_q.push_back(batch[i]);
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected output transaction: frame_byte %h", got.frame_byte);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.frame_byte !== exp.frame_byte) begin
        $error("frame_byte: expected %h, actual %h", exp.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.run_last !== exp.run_last) begin
        $error("run_last: expected %b, actual %b", exp.run_last, got.run_last);
        errors++;
      end
      if (got.frame_done !== exp.frame_done) begin
        $error("frame_done: expected %b, actual %b", exp.frame_done, got.frame_done);
        errors++;
      end
      if (got.orphan_error !== exp.orphan_error) begin
        $error("orphan_error: expected %b, actual %b", exp.orphan_error, got.orphan_error);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  lcfb_in_if  in_bus ();
  lcfb_out_if out_bus ();

  frame_scoreboard sb = new();

  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int cycles = 0;
  int flag_writes = 0;

  light_command_frame_builder dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("light_command_frame_builder verification failed");
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_result({out_bus.frame_byte, out_bus.run_last, out_bus.frame_done,
                       out_bus.orphan_error});
    end
  end

  // Output side: random back-pressure plus long hold-offs on request.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high on return.
  task automatic send_item(logic op, logic [7:0] ctype, logic [15:0] plen,
                           logic [7:0] pbyte);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid          = 1'b1;
    in_bus.opcode         = op;
    in_bus.command_type   = ctype;
    in_bus.payload_length = plen;
    in_bus.payload_byte   = pbyte;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_item(op, ctype, plen, pbyte);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_header(logic [7:0] ctype, logic [15:0] plen);
    send_item(lcfb_pkg::OP_HEADER, ctype, plen, 8'($urandom));
  endtask

  task automatic send_payload(logic [7:0] pbyte);
    send_item(lcfb_pkg::OP_PAYLOAD, 8'($urandom), 16'($urandom), pbyte);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_flag(logic idx, logic [7:0] value);
    logic [31:0] readback;
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = {idx, 2'b00};
    pwdata_i  = {24'h000000, value};
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    sb.set_flag(idx, value);
    flag_writes++;
    @(negedge clk_i);
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    readback = prdata_o;
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    if (readback[7:0] !== value) begin
      $error("flag readback: expected %h, actual %h", value, readback[7:0]);
      sb.errors++;
    end
  endtask

  task automatic set_flags(logic [7:0] start_value, logic [7:0] end_value);
    write_flag(lcfb_pkg::REG_START_FLAG, start_value);
    write_flag(lcfb_pkg::REG_END_FLAG, end_value);
  endtask

  // Mostly complete frames with random content; some truncated, abandoned,
  // oversized or orphan traffic mixed in.
  task automatic random_traffic(int target);
    int choice;
    int len;
    int count;
    while (items_sent < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        send_payload(8'($urandom));
      end else if (choice < 16) begin
        send_header(8'($urandom), 16'($urandom));
        count = $urandom_range(0, 5);
        repeat (count) send_payload(8'($urandom));
      end else begin
        len = $urandom_range(0, 9);
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        send_header(8'($urandom), 16'(len));
        repeat (count) send_payload(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel_i                = 1'b0;
    penable_i             = 1'b0;
    pwrite_i              = 1'b0;
    paddr_i               = '0;
    pwdata_i              = '0;
    in_bus.valid          = 1'b0;
    in_bus.opcode         = lcfb_pkg::OP_HEADER;
    in_bus.command_type   = '0;
    in_bus.payload_length = '0;
    in_bus.payload_byte   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, flags still at their reset value.
    send_payload(8'hff);              // orphan right after reset
    send_header(8'h00, 16'h0000);     // empty payload closes at once
    send_header(8'hff, 16'hffff);
    send_payload(8'h00);
    send_header(8'hab, 16'hcdef);     // abandons the open frame
    send_payload(8'h80);
    send_header(8'ha5, 16'h0002);
    send_payload(8'h00);
    send_payload(8'hff);
    send_payload(8'h5a);              // orphan after a closed frame
    send_header(8'h00, 16'h0001);     // hex chars sum to 0x21, 0xdf wraps it to zero
    send_payload(8'hdf);
    send_header(8'h3c, 16'h0100);
    send_payload(8'h7e);
    send_header(8'h12, 16'h0003);
    send_payload(8'h01);
    send_payload(8'h7f);
    send_payload(8'hfe);
    wait_drained();

    set_flags(8'hff, 8'h00);
    send_idle_pct = 11;
    recv_idle_pct = 82;
    random_traffic(130);
    wait_drained();

    set_flags(8'h00, 8'hff);
    send_idle_pct = 82;
    recv_idle_pct = 11;
    random_traffic(240);
    wait_drained();

    set_flags(8'($urandom), 8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_requests++;  // output stalls while the input keeps offering
    @(negedge clk_i);
    random_traffic(350);
    wait_drained();

    set_flags(8'h7e, 8'h7f);
    random_traffic(460);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Ran %0d input transactions (%0d headers, %0d payload) and checked %0d bytes",
             items_sent, sb.headers, sb.payloads, sb.results_seen);
    $display("%0d frames closed, %0d orphan bytes, %0d flag writes, one long output stall",
             sb.frames_closed, sb.orphans, flag_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("light_command_frame_builder verification clean");
    end else begin
      $display("light_command_frame_builder verification failed");
    end
    $finish;
  end

endmodule
